[src/etfs_pkg.sv]
// shared types, constants and log table for the smooth escape-time fractal block
package etfs_pkg;
	localparam int FRACTION_BITS_DEF  = 24;
	localparam int LOG_TABLE_BITS_DEF = 8;
	localparam int COUNT_BITS_DEF     = 16;
	localparam int NUM_CELLS          = 4;
	localparam int HALF_LN2_Q16       = 22713;

	localparam logic [2:0] REG_MODE  = 3'd0;
	localparam logic [2:0] REG_CRE   = 3'd1;
	localparam logic [2:0] REG_CIM   = 3'd2;
	localparam logic [2:0] REG_LIMIT = 3'd3;
	localparam logic [2:0] REG_BAIL  = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ITER,
		ST_LOG1,
		ST_SCALE,
		ST_LOG2,
		ST_DONE
	} etfs_state_t;

	// log2(1 + i/2^tb) in q.16, truncated, by repeated squaring
	function automatic logic [15:0] log_rom(input logic [11:0] i, input int tb);
		logic [63:0] x;
		logic [15:0] r;
		x = 64'd1 << 30;
		x = x + (64'(i) << (30 - tb));
		r = '0;
		for (int k = 0; k < 16; k++) begin
			x = (x * x) >> 30;
			r = {r[14:0], 1'b0};
			if (x >= (64'd2 << 30)) begin
				x = x >> 1;
				r[0] = 1'b1;
			end
		end
		return r;
	endfunction
endpackage

[src/etfs_cell.sv]
// one cell of the chain: a single orbit step z = z*z + c with saturation
module etfs_cell #(
	parameter int FB = etfs_pkg::FRACTION_BITS_DEF,
	parameter int CB = etfs_pkg::COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_run,
	input  logic [CB-1:0]       in_n,
	input  logic signed [FB+11:0] in_zr,
	input  logic signed [FB+11:0] in_zi,
	input  logic signed [31:0]  cr,
	input  logic signed [31:0]  ci,
	input  logic [CB-1:0]       limit,
	input  logic [39:0]         bail,
	output logic                out_valid,
	output logic                out_run,
	output logic [CB-1:0]       out_n,
	output logic signed [FB+11:0] out_zr,
	output logic signed [FB+11:0] out_zi
);
	import etfs_pkg::*;
	localparam int ZB = FB + 12;
	localparam int PB = 2 * ZB;

	logic [ZB-1:0] mr, mi;
	logic [PB-1:0] pr2, pi2, prr;
	logic [PB-1:0] sr2, si2, srr;
	logic [PB:0] msum;
	logic go;
	logic signed [PB+2:0] nzi, nzr, zmax, zmin;
	logic signed [ZB-1:0] szr, szi;

	assign mr = in_zr[ZB-1] ? ZB'(-in_zr) : ZB'(in_zr);
	assign mi = in_zi[ZB-1] ? ZB'(-in_zi) : ZB'(in_zi);
	assign pr2 = PB'(mr) * PB'(mr);
	assign pi2 = PB'(mi) * PB'(mi);
	assign prr = PB'(mr) * PB'(mi);
	assign sr2 = pr2 >> FB;
	assign si2 = pi2 >> FB;
	assign srr = prr >> FB;
	assign zmax = (PB+3)'((64'd1 << (ZB-1)) - 1);
	assign zmin = -zmax - 1;

	// step only while under the limit and inside the bailout
	assign msum = (PB+1)'(sr2) + (PB+1)'(si2);
	assign go = in_run && (in_n < limit) && (msum <= (PB+1)'(bail));

	always_comb begin
		nzi = (in_zr[ZB-1] != in_zi[ZB-1]) ? -(PB+3)'({srr, 1'b0}) : (PB+3)'({srr, 1'b0});
		nzi = nzi + (PB+3)'(ci);
		nzr = (PB+3)'(sr2) - (PB+3)'(si2) + (PB+3)'(cr);
		szi = (nzi > zmax) ? ZB'(zmax) : (nzi < zmin) ? ZB'(zmin) : ZB'(nzi);
		szr = (nzr > zmax) ? ZB'(zmax) : (nzr < zmin) ? ZB'(zmin) : ZB'(nzr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			out_run   <= 1'b0;
		end else begin
			out_valid <= in_valid;
			out_run   <= go;
		end
	end

	always_ff @(posedge clk) begin
		out_zr <= go ? szr : in_zr;
		out_zi <= go ? szi : in_zi;
		out_n  <= go ? in_n + 1'b1 : in_n;
	end
endmodule

[src/etfs_log2.sv]
// log2 in q.16 by leading-one detection and table lookup, registered
module etfs_log2 #(
	parameter int TB = etfs_pkg::LOG_TABLE_BITS_DEF
) (
	input  logic               clk,
	input  logic [63:0]        v,
	input  logic [6:0]         fb,
	output logic signed [23:0] res
);
	import etfs_pkg::*;
	logic [5:0] p;
	logic [TB-1:0] idx;
	logic [63+TB:0] ext;
	logic signed [23:0] whole;
	logic [15:0] rom [1 << TB];

	genvar gi;
	generate
		for (gi = 0; gi < (1 << TB); gi++) begin : g_rom
			assign rom[gi] = log_rom(12'(gi), TB);
		end
	endgenerate

	always_comb begin
		p = '0;
		for (int k = 0; k < 64; k++) begin
			if (v[k]) p = 6'(k);
		end
		ext = {v, TB'(0)} >> p;
		idx = ext[TB-1:0];
		whole = 24'($signed({1'b0, p})) - 24'($signed({1'b0, fb}));
	end

	always_ff @(posedge clk) begin
		res <= (whole <<< 16) + $signed({8'd0, rom[idx]});
	end
endmodule

[src/escape_time_fractal_smooth.sv]
// top level: config registers, chain of orbit cells and smooth count sequencer
// sequence: after start is taken the item passes round the chain of cells until it stops; an escaped item
// then goes through ST_LOG1, ST_SCALE, ST_LOG2 and ST_DONE, otherwise straight to ST_DONE; done is registered
// throughput: one item at a time, set by the iteration count; start is taken again while done is high
// reset: config returns to Mandelbrot, zero constant, limit 256, bailout 4.0; nothing in flight
// the result strobe lasts one cycle; the receiver cannot stall
module escape_time_fractal_smooth #(
	parameter int FRACTION_BITS  = etfs_pkg::FRACTION_BITS_DEF,
	parameter int LOG_TABLE_BITS = etfs_pkg::LOG_TABLE_BITS_DEF,
	parameter int COUNT_BITS     = etfs_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic signed [31:0]    point_re,
	input  logic signed [31:0]    point_im,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [39:0]           cfg_data,
	output logic                  done,
	output logic signed [25:0]    smooth_count,
	output logic [COUNT_BITS-1:0] iteration_total,
	output logic                  escaped
);
	import etfs_pkg::*;
	localparam int ZB = FRACTION_BITS + 12;

	logic mode_q;
	logic signed [31:0] jcr_q, jci_q, cr_q, ci_q;
	logic [COUNT_BITS-1:0] limit_q, n_q;
	logic [39:0] bail_q;
	etfs_state_t state_q, state_d;

	logic signed [ZB-1:0] zr_q, zi_q;
	logic [63:0] mag_q;
	logic chk_q;
	logic run_q;

	logic signed [ZB-1:0] czr [NUM_CELLS+1];
	logic signed [ZB-1:0] czi [NUM_CELLS+1];
	logic [COUNT_BITS-1:0] cn [NUM_CELLS+1];
	logic cv [NUM_CELLS+1];
	logic crun [NUM_CELLS+1];

	logic [63:0] lv;
	logic [6:0] lfb;
	logic signed [23:0] lres;
	logic [63:0] y_q;
	logic signed [47:0] s;
	logic signed [39:0] sm;

	assign cfg_ready = !busy;
	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			jcr_q   <= '0;
			jci_q   <= '0;
			limit_q <= COUNT_BITS'(256);
			bail_q  <= 40'd67108864;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE:  mode_q  <= cfg_data[0];
				REG_CRE:   jcr_q   <= cfg_data[31:0];
				REG_CIM:   jci_q   <= cfg_data[31:0];
				REG_LIMIT: limit_q <= COUNT_BITS'(cfg_data[15:0]);
				REG_BAIL:  bail_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ring of cells: each cell checks and steps once, the item goes round until it stops
	assign czr[0]  = zr_q;
	assign czi[0]  = zi_q;
	assign cn[0]   = n_q;
	assign cv[0]   = (state_q == ST_ITER) && chk_q && run_q;
	assign crun[0] = cv[0];

	logic [ZB-1:0] amr, ami;
	logic [2*ZB-1:0] sq_r, sq_i;
	logic [64:0] msum;
	assign amr = zr_q[ZB-1] ? ZB'(-zr_q) : ZB'(zr_q);
	assign ami = zi_q[ZB-1] ? ZB'(-zi_q) : ZB'(zi_q);
	assign sq_r = (2*ZB)'(amr) * (2*ZB)'(amr);
	assign sq_i = (2*ZB)'(ami) * (2*ZB)'(ami);
	assign msum = 65'(sq_r >> FRACTION_BITS) + 65'(sq_i >> FRACTION_BITS);

	genvar g;
	generate
		for (g = 0; g < NUM_CELLS; g++) begin : g_cell
			etfs_cell #(.FB(FRACTION_BITS), .CB(COUNT_BITS)) u_cell (
				.clk(clk), .arst_n(arst_n),
				.in_valid(cv[g]), .in_run(crun[g]), .in_n(cn[g]),
				.in_zr(czr[g]), .in_zi(czi[g]), .cr(cr_q), .ci(ci_q),
				.limit(limit_q), .bail(bail_q),
				.out_valid(cv[g+1]), .out_run(crun[g+1]), .out_n(cn[g+1]),
				.out_zr(czr[g+1]), .out_zi(czi[g+1])
			);
		end
	endgenerate

	logic [63:0] y_fix;
	assign y_fix = (y_q == 0) ? 64'd1 : y_q;

	etfs_log2 #(.TB(LOG_TABLE_BITS)) u_log (.clk(clk), .v(lv), .fb(lfb), .res(lres));
	assign lv  = (state_q == ST_LOG1) ? mag_q : y_fix;
	assign lfb = (state_q == ST_LOG1) ? 7'(FRACTION_BITS) : 7'd16;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_ITER;
			ST_ITER:  if (chk_q && !run_q)
				state_d = (n_q < limit_q) ? ST_LOG1 : ST_DONE;
			ST_LOG1:  state_d = ST_SCALE;
			ST_SCALE: state_d = ST_LOG2;
			ST_LOG2:  state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chk_q   <= 1'b0;
			run_q   <= 1'b0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && start) begin
				chk_q <= 1'b1;
				run_q <= 1'b1;
				n_q   <= '0;
			end else if (state_q == ST_ITER) begin
				if (chk_q) begin
					chk_q <= 1'b0;
				end else if (cv[NUM_CELLS]) begin
					chk_q <= 1'b1;
					run_q <= crun[NUM_CELLS];
					n_q   <= cn[NUM_CELLS];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			zr_q <= mode_q ? ZB'(point_re) : '0;
			zi_q <= mode_q ? ZB'(point_im) : '0;
			cr_q <= mode_q ? jcr_q : point_re;
			ci_q <= mode_q ? jci_q : point_im;
		end else if (state_q == ST_ITER && !chk_q && cv[NUM_CELLS]) begin
			zr_q <= czr[NUM_CELLS];
			zi_q <= czi[NUM_CELLS];
		end
		if (state_q == ST_ITER) mag_q <= msum[63:0];
		if (state_q == ST_SCALE) begin
			y_q <= (lres > 0) ? 64'((40'(lres) * 40'(HALF_LN2_Q16)) >> 16) : 64'd1;
		end
	end

	assign s = ((48'(n_q) + 48'd1) <<< 16) - 48'(lres) + 48'sd128;
	assign sm = 40'(s >>> 8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
			escaped <= 1'b0;
		end else begin
			done <= (state_q == ST_DONE);
			if (state_q == ST_LOG2) escaped <= 1'b1;
			else if (state_q == ST_ITER) escaped <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && escaped) begin
			smooth_count <= (sm > 40'sd33554431) ? 26'sd33554431 :
				(sm < -40'sd33554432) ? -26'sd33554432 : 26'(sm);
			iteration_total <= n_q;
		end else if (state_q == ST_ITER) begin
			smooth_count <= 26'(40'(limit_q) <<< 8);
			iteration_total <= n_q;
		end
	end
endmodule
